@@ src/obst_pkg.sv @@
// ----------------------------------------------------------------------------
// obst_pkg
// shared constants and the sequencer state type of the optimal bst cost block
// ----------------------------------------------------------------------------
package obst_pkg;

  localparam int MAX_KEYS_DEF    = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int MIN_COST_W      = 28;

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,     // taking key weights
    ST_FETCH,    // read root bounds and prefix sums of the interval
    ST_BOUNDS,   // form root range and span
    ST_SCAN,     // one root trial issued per cycle
    ST_DRAIN1,   // trial pipeline draining
    ST_DRAIN2,
    ST_WRITE,    // write cost and root of the interval
    ST_RES_RD,   // read cost of the whole range
    ST_RES       // load the result register
  } obst_state_t;

endpackage

@@ src/optimal_bst_cost_knuth_dp.sv @@
// ----------------------------------------------------------------------------
// optimal_bst_cost_knuth_dp
// minimum weighted search cost of an optimal binary search tree, knuth dp
// ----------------------------------------------------------------------------
// Key weights arrive one beat each, in sorted key order; a beat with last set
// closes the set. Loading never stalls the input and writes the running
// prefix sum and the single-key interval straight into the tables. After the
// last beat the block stalls its input and fills the interval table shortest
// intervals first, with the root range narrowed by Knuth's bound. Each
// interval passes through fetch, bounds, a scan of its root trials, drain
// and write; the cost/root table has one write port and two read ports and
// one trial is issued per cycle. For n keys the trials number typically n*n,
// at most 2*n*n. The result is then read out through the result-read and
// result states and sits in an output register while the next set already
// loads. Keys beyond MAX_KEYS are dropped and set the overflow bit of the
// result; a dropped last beat still closes the set.
module optimal_bst_cost_knuth_dp #(
  parameter int MAX_KEYS    = obst_pkg::MAX_KEYS_DEF,
  parameter int WEIGHT_BITS = obst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // weight channel
  input  logic                           weight_valid,
  output logic                           weight_stall,
  input  logic [WEIGHT_BITS-1:0]         weight,
  input  logic                           last,
  // result channel
  output logic                           cost_valid,
  input  logic                           cost_stall,
  output logic [obst_pkg::MIN_COST_W-1:0] min_cost,
  output logic                           overflow
);
  import obst_pkg::*;

  // key index, key count, prefix sum and cost widths
  localparam int IDX_W     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W     = IDX_W + 1;
  localparam int PS_W      = WEIGHT_BITS + IDX_W + 1;
  localparam int COST_W    = PS_W + IDX_W + 1;
  localparam int TBL_W     = IDX_W + COST_W;
  localparam int PS_DEPTH  = 1 << IDX_W;
  localparam int TBL_DEPTH = 1 << (2 * IDX_W);

  obst_state_t state, state_next;

  // set bookkeeping
  logic [CNT_W-1:0]  key_count;
  logic              overflow_seen;
  logic [PS_W-1:0]   ps_run;

  // interval walk
  logic [CNT_W-1:0]  len;
  logic [IDX_W-1:0]  i_idx, j_idx, k_idx, hi_idx;
  logic [PS_W-1:0]   span;

  // trial pipeline
  logic              s1_valid, s1_left_ok, s1_right_ok;
  logic [IDX_W-1:0]  s1_k;
  logic              s2_valid;
  logic [IDX_W-1:0]  s2_k;
  logic [COST_W-1:0] s2_val;
  logic              found;
  logic [COST_W-1:0] best_cost;
  logic [IDX_W-1:0]  best_root;

  // memories: prefix sum before each key, and {root, cost} per interval
  logic [PS_W-1:0]   ps_mem [PS_DEPTH];
  logic [TBL_W-1:0]  tbl_mem [TBL_DEPTH];
  logic [PS_W-1:0]   ps_rd_a, ps_rd_b;
  logic [TBL_W-1:0]  tbl_rd_a, tbl_rd_b;

  logic              ps_we;
  logic [IDX_W-1:0]  ps_wa, ps_ra_a, ps_ra_b;
  logic              tbl_we;
  logic [2*IDX_W-1:0] tbl_wa, tbl_ra_a, tbl_ra_b;
  logic [TBL_W-1:0]  tbl_wd;

  // derived control
  logic              in_fire, full, last_col, out_free;
  logic [CNT_W-1:0]  cnt_after, cnt_m1;
  logic [IDX_W-1:0]  key_idx;
  logic [IDX_W-1:0]  lo_rd, hi_rd, hi_eff;
  logic [PS_W-1:0]   ps_hi;
  logic [COST_W-1:0] left_cost, right_cost, s1_sum;
  logic [COST_W+MIN_COST_W-1:0] cost_ext;

  assign in_fire   = weight_valid && !weight_stall;
  assign full      = (key_count == CNT_W'(MAX_KEYS));
  assign cnt_after = full ? key_count : key_count + CNT_W'(1);
  assign cnt_m1    = key_count - CNT_W'(1);
  assign key_idx   = key_count[IDX_W-1:0];
  // interval ends at the final key: upper root bound is j itself
  assign last_col  = (({1'b0, j_idx} + CNT_W'(1)) == key_count);
  assign out_free  = !cost_valid || !cost_stall;

  // root bounds and span from the fetch reads
  assign lo_rd  = tbl_rd_a[TBL_W-1:COST_W];
  assign hi_rd  = last_col ? j_idx : tbl_rd_b[TBL_W-1:COST_W];
  assign hi_eff = (hi_rd < lo_rd) ? lo_rd : hi_rd;
  assign ps_hi  = last_col ? ps_run : ps_rd_b;

  // trial value: left subtree + right subtree + interval weight
  assign left_cost  = s1_left_ok  ? tbl_rd_a[COST_W-1:0] : '0;
  assign right_cost = s1_right_ok ? tbl_rd_b[COST_W-1:0] : '0;
  assign s1_sum     = left_cost + right_cost + COST_W'(span);

  assign cost_ext = {{MIN_COST_W{1'b0}}, tbl_rd_a[COST_W-1:0]};

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (ps_we) begin
      ps_mem[ps_wa] <= ps_run;
    end
    ps_rd_a <= ps_mem[ps_ra_a];
    ps_rd_b <= ps_mem[ps_ra_b];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_rd_a <= tbl_mem[tbl_ra_a];
    tbl_rd_b <= tbl_mem[tbl_ra_b];
  end

  // -------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_fire && last) begin
          state_next = (cnt_after == CNT_W'(1)) ? ST_RES_RD : ST_FETCH;
        end
      end
      ST_FETCH:  state_next = ST_BOUNDS;
      ST_BOUNDS: state_next = ST_SCAN;
      ST_SCAN: begin
        if (k_idx == hi_idx) begin
          state_next = ST_DRAIN1;
        end
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_WRITE;
      ST_WRITE: begin
        // writes land before the next fetch, so no read ever sees a stale entry
        state_next = (last_col && (len == key_count)) ? ST_RES_RD : ST_FETCH;
      end
      ST_RES_RD: state_next = ST_RES;
      ST_RES: begin
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // ----------------------------------------------------------------- outputs
  always_comb begin
    weight_stall = 1'b1;
    ps_we    = 1'b0;
    ps_wa    = key_idx;
    ps_ra_a  = i_idx;
    ps_ra_b  = j_idx + IDX_W'(1);
    tbl_we   = 1'b0;
    tbl_wa   = {i_idx, j_idx};
    tbl_wd   = {best_root, best_cost};
    tbl_ra_a = {i_idx, j_idx - IDX_W'(1)};
    tbl_ra_b = {i_idx + IDX_W'(1), j_idx};
    unique case (state)
      ST_LOAD: begin
        // input is never stalled here, so a valid beat is taken
        weight_stall = 1'b0;
        // single-key interval: cost is the weight, root is the key
        ps_we  = weight_valid && !full;
        tbl_we = weight_valid && !full;
        tbl_wa = {key_idx, key_idx};
        tbl_wd = {key_idx, COST_W'(weight)};
      end
      ST_FETCH: begin
        // root[i][j-1] on port a, root[i+1][j] on port b
      end
      ST_SCAN: begin
        tbl_ra_a = {i_idx, k_idx - IDX_W'(1)};
        tbl_ra_b = {k_idx + IDX_W'(1), j_idx};
      end
      ST_WRITE: begin
        tbl_we = 1'b1;
      end
      ST_RES_RD, ST_RES: begin
        tbl_ra_a = {IDX_W'(0), cnt_m1[IDX_W-1:0]};
      end
      ST_BOUNDS, ST_DRAIN1, ST_DRAIN2: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      key_count     <= '0;
      overflow_seen <= 1'b0;
      ps_run        <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      found         <= 1'b0;
      cost_valid    <= 1'b0;
    end else begin
      state <= state_next;

      // result register: loaded in the result state, else emptied when taken
      if ((state == ST_RES) && out_free) begin
        cost_valid <= 1'b1;
      end else if (cost_valid && !cost_stall) begin
        cost_valid <= 1'b0;
      end

      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (full) begin
              overflow_seen <= 1'b1;
            end else begin
              ps_run    <= ps_run + PS_W'(weight);
              key_count <= cnt_after;
            end
            if (last) begin
              len   <= CNT_W'(2);
              i_idx <= '0;
              j_idx <= IDX_W'(1);
            end
          end
        end
        ST_BOUNDS: begin
          k_idx  <= lo_rd;
          hi_idx <= hi_eff;
          span   <= ps_hi - ps_rd_a;
          found  <= 1'b0;
        end
        ST_SCAN: begin
          if (k_idx != hi_idx) begin
            k_idx <= k_idx + IDX_W'(1);
          end
        end
        ST_WRITE: begin
          if (last_col) begin
            // next diagonal
            len   <= len + CNT_W'(1);
            i_idx <= '0;
            j_idx <= len[IDX_W-1:0];
          end else begin
            i_idx <= i_idx + IDX_W'(1);
            j_idx <= j_idx + IDX_W'(1);
          end
        end
        ST_RES: begin
          if (out_free) begin
            min_cost      <= cost_ext[MIN_COST_W-1:0];
            overflow      <= overflow_seen;
            key_count     <= '0;
            overflow_seen <= 1'b0;
            ps_run        <= '0;
          end
        end
        ST_FETCH, ST_DRAIN1, ST_DRAIN2, ST_RES_RD: begin
        end
        default: begin
        end
      endcase

      // trial pipeline: issue, sum, compare; first strictly smaller wins
      s1_valid <= (state == ST_SCAN);
      s2_valid <= s1_valid;
      if (s2_valid && (!found || (s2_val < best_cost))) begin
        found     <= 1'b1;
        best_cost <= s2_val;
        best_root <= s2_k;
      end
    end
  end

  // trial pipeline payload
  always_ff @(posedge clk) begin
    s1_k        <= k_idx;
    s1_left_ok  <= (k_idx != i_idx);
    s1_right_ok <= (k_idx != j_idx);
    s2_k        <= s1_k;
    s2_val      <= s1_sum;
  end

  // -------------------------------------------------------------- assertions
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (k_idx <= hi_idx))
    else $error("root trial beyond upper bound");

  a_root_in_interval: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (found && (best_root >= i_idx) && (best_root <= j_idx)))
    else $error("written root outside its interval");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= CNT_W'(MAX_KEYS))
    else $error("key count above capacity");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(cost_valid) |-> ($past(state) == ST_RES))
    else $error("result beat raised outside result state");

endmodule

@@ tb/optimal_bst_cost_knuth_dp_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// optimal_bst_cost_knuth_dp_tb
// self-checking bench for the optimal bst cost block
// ----------------------------------------------------------------------------
// Sends sets of key weights on the weight channel and predicts the minimum
// weighted search cost of each set with its own interval dp. Each result
// beat is compared with the oldest prediction. Covers corner sets, full and
// overflowing sets, a long hold on the result side, and random sets with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module optimal_bst_cost_knuth_dp_tb;
  import obst_pkg::*;

  localparam int KEY_CAP      = MAX_KEYS_DEF;
  localparam int WB           = WEIGHT_BITS_DEF;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int LONG_HOLD    = 1500;
  localparam int TAIL_CYCLES  = 500;
  localparam int RANDOM_END   = 1750;
  localparam int ITEMS_TOTAL  = 1900;
  localparam int EXP_DEPTH    = 64;

  // how the weights of a random set are drawn
  typedef enum int {
    W_ANY,     // full 16-bit range
    W_TINY,    // 0..3, lots of ties
    W_SPARSE,  // mostly zero
    W_HEAVY    // close to the top of the range
  } weight_mix_t;

  typedef struct packed {
    logic [MIN_COST_W-1:0] cost;
    logic                  ovf;
  } cost_beat_t;

  logic                  clk;
  logic                  rst;
  logic                  weight_valid;
  logic                  weight_stall;
  logic [WB-1:0]         weight;
  logic                  last;
  logic                  cost_valid;
  logic                  cost_stall;
  logic [MIN_COST_W-1:0] min_cost;
  logic                  overflow;

  // shaping of traffic
  bit tx_gaps    = 1'b0;  // sender inserts idle bursts
  bit rx_jitter  = 1'b0;  // receiver inserts stall bursts
  int hold_asked = 0;     // bumped to ask the receiver for one long hold

  int beats_sent = 0;
  int errors     = 0;

  // predictor state: current set and the dp tables
  int unsigned     keys_held;
  bit              overflow_pending;
  longint unsigned weight_prefix [0:KEY_CAP];
  longint unsigned span_cost [KEY_CAP][KEY_CAP];
  int              span_root [KEY_CAP][KEY_CAP];

  // expected results, oldest first, as a ring with free-running counters
  cost_beat_t      expected_costs [EXP_DEPTH];
  int              exp_wr = 0;
  int              exp_rd = 0;

  optimal_bst_cost_knuth_dp #(
    .MAX_KEYS    (KEY_CAP),
    .WEIGHT_BITS (WB)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .weight_valid (weight_valid),
    .weight_stall (weight_stall),
    .weight       (weight),
    .last         (last),
    .cost_valid   (cost_valid),
    .cost_stall   (cost_stall),
    .min_cost     (min_cost),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // interval dp over the n stored keys, shortest intervals first; the root
  // search is narrowed to [root(i,j-1), root(i+1,j)], running up to j when j
  // is the final key; the first strictly smaller candidate wins
  function automatic logic [MIN_COST_W-1:0] tree_cost(input int n);
    int              len, i, j, k, lo, hi, root;
    longint unsigned span, best, left, right, cand, whole;
    bit              found;
    for (i = 0; i < n; i++) begin
      span_cost[i][i] = weight_prefix[i+1] - weight_prefix[i];
      span_root[i][i] = i;
    end
    for (len = 2; len <= n; len++) begin
      for (i = 0; i + len - 1 < n; i++) begin
        j     = i + len - 1;
        span  = weight_prefix[j+1] - weight_prefix[i];
        lo    = span_root[i][j-1];
        hi    = (j + 1 < n) ? span_root[i+1][j] : j;
        // empty root range: only the lower bound is tried
        if (hi < lo) hi = lo;
        root  = lo;
        best  = 0;
        found = 1'b0;
        for (k = lo; k <= hi; k++) begin
          left  = (k > i) ? span_cost[i][k-1] : 64'd0;
          right = (k < j) ? span_cost[k+1][j] : 64'd0;
          cand  = left + right + span;
          if (!found || cand < best) begin
            best  = cand;
            root  = k;
            found = 1'b1;
          end
        end
        span_cost[i][j] = best;
        span_root[i][j] = root;
      end
    end
    whole = span_cost[0][n-1];
    return whole[MIN_COST_W-1:0];
  endfunction

  // one accepted weight beat; a closing beat yields one expected result
  function automatic void take_key(input logic [WB-1:0] w, input logic lst);
    cost_beat_t r;
    if (keys_held < KEY_CAP) begin
      weight_prefix[keys_held+1] = weight_prefix[keys_held] + w;
      keys_held++;
    end else begin
      // past capacity: weight dropped, but a last flag still closes the set
      overflow_pending = 1'b1;
    end
    if (lst) begin
      r.cost = (keys_held > 0) ? tree_cost(keys_held) : '0;
      r.ovf  = overflow_pending;
      expected_costs[exp_wr[5:0]] = r;
      exp_wr++;
      keys_held        = 0;
      overflow_pending = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // result side: stall driver and checker
  // --------------------------------------------------------------------------

  // random stall bursts, or one long hold when asked
  initial begin : result_stall_driver
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    cost_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen  = hold_asked;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        cost_stall <= 1'b1;
        stall_left--;
      end else if (rx_jitter && $urandom_range(0, 5) == 0) begin
        cost_stall <= 1'b1;
        stall_left = $urandom_range(0, 12);
      end else begin
        cost_stall <= 1'b0;
      end
    end
  end

  // every accepted result beat is matched against the oldest prediction
  always @(posedge clk) begin : cost_checker
    cost_beat_t want;
    if (!rst && cost_valid && !cost_stall) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: result beat with none expected, min_cost %0d overflow %0b",
                 $time, min_cost, overflow);
        errors++;
      end else begin
        want = expected_costs[exp_rd[5:0]];
        exp_rd++;
        if (min_cost !== want.cost) begin
          $display("%0t: min_cost mismatch, expected %0d, got %0d",
                   $time, want.cost, min_cost);
          errors++;
        end
        if (overflow !== want.ovf) begin
          $display("%0t: overflow mismatch, expected %0b, got %0b",
                   $time, want.ovf, overflow);
          errors++;
        end
      end
    end
  end

  // hang guard
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout, %0d results still expected", $time, exp_wr - exp_rd);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // weight side
  // --------------------------------------------------------------------------

  // offers one beat, optionally after an idle burst, and holds it until taken
  task automatic send_key(input logic [WB-1:0] w, input logic lst);
    int gap;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      weight_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    weight_valid <= 1'b1;
    weight       <= w;
    last         <= lst;
    @(posedge clk);
    while (weight_stall) @(posedge clk);
    take_key(w, lst);
    beats_sent++;
  endtask

  function automatic logic [WB-1:0] pick_weight(input weight_mix_t mix);
    logic [31:0] r;
    r = $urandom;
    case (mix)
      W_TINY:   return {{(WB-2){1'b0}}, r[1:0]};
      W_SPARSE: return (r[31:29] == 3'd0) ? r[WB-1:0] : '0;
      W_HEAVY:  return ~{{(WB-3){1'b0}}, r[2:0]};
      default:  return r[WB-1:0];
    endcase
  endfunction

  task automatic send_set(input int n_keys, input weight_mix_t mix);
    int k;
    for (k = 0; k < n_keys; k++) send_key(pick_weight(mix), k == n_keys - 1);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // short hand-built sets: weight extremes, bit patterns, ties, skew
  task automatic test_corner_sets();
    int k;
    tx_gaps = 1'b0;
    rx_jitter <= 1'b0;
    send_key('0, 1'b1);                  // one key, zero weight
    send_key('1, 1'b1);                  // one key, top weight
    send_key('1, 1'b0);
    send_key('1, 1'b1);
    for (k = 0; k < 3; k++) send_key('0, k == 2);  // all-zero ties
    send_key(16'hAAAA, 1'b0);
    send_key(16'h5555, 1'b0);
    send_key(16'hFFFF, 1'b0);
    send_key(16'h0001, 1'b0);
    send_key(16'h8000, 1'b1);
    for (k = 0; k < 6; k++) send_key(16'h0001, k == 5);  // equal weights
    send_key('1, 1'b0);                  // heavy ends, empty middle
    send_key('0, 1'b0);
    send_key('0, 1'b0);
    send_key('0, 1'b0);
    send_key('1, 1'b1);
  endtask

  // exactly as many keys as the tables hold
  task automatic test_full_capacity();
    int k;
    tx_gaps = 1'b1;
    rx_jitter <= 1'b1;
    for (k = 0; k < KEY_CAP; k++) send_key('1, k == KEY_CAP - 1);
    send_set(KEY_CAP, W_ANY);
  endtask

  // keys past capacity are dropped; the next set starts clean
  task automatic test_overflow();
    tx_gaps = 1'b1;
    send_set(KEY_CAP + 1, W_ANY);        // closing beat itself is dropped
    send_set(KEY_CAP + 6, W_TINY);
    send_set(3, W_ANY);                  // overflow flag must be cleared again
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    int s;
    tx_gaps = 1'b0;
    rx_jitter <= 1'b0;
    hold_asked <= hold_asked + 1;
    for (s = 0; s < 6; s++) send_set(4, W_ANY);
  endtask

  // random well-formed sets, mostly small, with occasional big and
  // overflowing ones; idling switched on and off per set
  task automatic test_random_sets();
    int          n, pick;
    weight_mix_t mix;
    while (beats_sent < RANDOM_END) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_jitter <= ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70)      n = $urandom_range(1, 8);
      else if (pick < 92) n = $urandom_range(9, 24);
      else if (pick < 98) n = $urandom_range(25, 48);
      else                n = $urandom_range(49, KEY_CAP + 6);
      pick = $urandom_range(0, 9);
      if (pick < 5)      mix = W_ANY;
      else if (pick < 7) mix = W_TINY;
      else if (pick < 9) mix = W_SPARSE;
      else               mix = W_HEAVY;
      send_set(n, mix);
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_quiet_tail();
    tx_gaps = 1'b0;
    rx_jitter <= 1'b0;
    while (beats_sent < ITEMS_TOTAL) send_set($urandom_range(1, 8), W_ANY);
  endtask

  initial begin : stimulus
    rst          <= 1'b1;
    weight_valid <= 1'b0;
    weight       <= '0;
    last         <= 1'b0;
    keys_held        = 0;
    overflow_pending = 1'b0;
    weight_prefix[0] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_sets();
    test_full_capacity();
    test_overflow();
    test_output_backpressure();
    test_random_sets();
    test_quiet_tail();
    weight_valid <= 1'b0;

    // drain: wait for every predicted result, then watch for strays
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
src/obst_pkg.sv
src/optimal_bst_cost_knuth_dp.sv
tb/optimal_bst_cost_knuth_dp_tb.sv
